/* rtl/rational_arithmetic_unit_defines.svh */
// Assertion macros shared by the rational arithmetic unit RTL.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication on clk_i, off while rst_ni is low.
`define RAU_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk_i, off while rst_ni is low.
`define RAU_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rau_pkg.sv */
// Types, codes and microcode table of the rational arithmetic unit.
`default_nettype none

package rau_pkg;

  localparam int unsigned OperandWidthDefault = 16;
  localparam int unsigned PcWidth             = 5;

  typedef logic [PcWidth-1:0] pc_t;

  localparam pc_t PcFinEq   = pc_t'(23);
  localparam pc_t PcFinZero = pc_t'(24);

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4
  } op_e;

  typedef enum logic [1:0] {G_NONE, G_INIT, G_STEP} gcd_op_e;
  typedef enum logic [1:0] {D_NONE, D_INIT, D_STEP} div_op_e;

  typedef enum logic [2:0] {
    WS_HOLD, WS_LEFT, WS_RIGHT, WS_QUOT, WS_PROD_N, WS_COMBINE_N, WS_PROD_D
  } wsel_e;

  typedef enum logic [1:0] {M_NONE, M_N1, M_N2, M_D} mul_e;

  typedef enum logic [2:0] {
    C_NEVER, C_GCD_BUSY, C_G_ZERO, C_DIV_MORE, C_OP_EQ, C_OP_BAD
  } cond_e;

  typedef enum logic [1:0] {F_NONE, F_ARITH, F_EQ, F_ZERO} fin_e;

  typedef struct packed {
    gcd_op_e gop;
    div_op_e dop;
  } red_ctrl_t;

  typedef struct packed {
    logic gcd_busy;
    logic g_zero;
    logic div_more;
  } red_stat_t;

  typedef struct packed {
    red_ctrl_t red;
    wsel_e     wsel;
    logic      save_l;
    logic      save_r;
    mul_e      mul;
    cond_e     cond;
    pc_t       target;
    fin_e      fin;
  } uword_t;

  // Program: reduce left, right; arithmetic: cross-multiply, reduce.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    w = '{red: '{gop: G_NONE, dop: D_NONE}, wsel: WS_HOLD, save_l: 1'b0,
          save_r: 1'b0, mul: M_NONE, cond: C_NEVER, target: '0, fin: F_NONE};
    case (pc)
      5'd0:  begin w.wsel = WS_LEFT; w.cond = C_OP_BAD; w.target = PcFinZero; end
      5'd1:  w.red.gop = G_INIT;
      5'd2:  begin w.red.gop = G_STEP; w.cond = C_GCD_BUSY; w.target = 5'd2; end
      5'd3:  begin w.red.dop = D_INIT; w.cond = C_G_ZERO; w.target = 5'd6; end
      5'd4:  begin w.red.dop = D_STEP; w.cond = C_DIV_MORE; w.target = 5'd4; end
      5'd5:  w.wsel = WS_QUOT;
      5'd6:  begin w.save_l = 1'b1; w.wsel = WS_RIGHT; end
      5'd7:  w.red.gop = G_INIT;
      5'd8:  begin w.red.gop = G_STEP; w.cond = C_GCD_BUSY; w.target = 5'd8; end
      5'd9:  begin w.red.dop = D_INIT; w.cond = C_G_ZERO; w.target = 5'd12; end
      5'd10: begin w.red.dop = D_STEP; w.cond = C_DIV_MORE; w.target = 5'd10; end
      5'd11: w.wsel = WS_QUOT;
      5'd12: begin w.save_r = 1'b1; w.cond = C_OP_EQ; w.target = PcFinEq; end
      5'd13: w.mul = M_N1;
      5'd14: begin w.mul = M_N2; w.wsel = WS_PROD_N; end
      5'd15: begin w.mul = M_D; w.wsel = WS_COMBINE_N; end
      5'd16: w.wsel = WS_PROD_D;
      5'd17: w.red.gop = G_INIT;
      5'd18: begin w.red.gop = G_STEP; w.cond = C_GCD_BUSY; w.target = 5'd18; end
      5'd19: begin w.red.dop = D_INIT; w.cond = C_G_ZERO; w.target = 5'd22; end
      5'd20: begin w.red.dop = D_STEP; w.cond = C_DIV_MORE; w.target = 5'd20; end
      5'd21: w.wsel = WS_QUOT;
      5'd22: w.fin = F_ARITH;
      5'd23: w.fin = F_EQ;
      default: w.fin = F_ZERO;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

/* rtl/rau_reduce.sv */
// Fraction reduction unit: binary gcd, then two restoring exact divisions.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"

module rau_reduce #(
  parameter int unsigned DATA_WIDTH = 2 * rau_pkg::OperandWidthDefault + 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rau_pkg::red_ctrl_t           ctrl_i,
  input  logic signed [DATA_WIDTH-1:0] num_i,
  input  logic signed [DATA_WIDTH-1:0] den_i,
  output rau_pkg::red_stat_t           stat_o,
  output logic signed [DATA_WIDTH-1:0] num_o,
  output logic signed [DATA_WIDTH-1:0] den_o
);

  localparam int unsigned CntWidth = $clog2(DATA_WIDTH + 1);

  logic signed [DATA_WIDTH-1:0] num_neg, den_neg;
  logic [DATA_WIDTH-1:0] num_mag, den_mag;

  logic [DATA_WIDTH-1:0] u_q, u_d, v_q, v_d;
  logic [CntWidth-1:0]   k_q, k_d;
  logic                  u_zero, v_zero, gcd_done;
  logic [DATA_WIDTH-1:0] g_val, g_q;
  logic [DATA_WIDTH:0]   uv_sum;

  logic [DATA_WIDTH-1:0] an_q, ad_q, rn_q, rd_q;
  logic                  sn_q, sd_q;
  logic [CntWidth-1:0]   cnt_q, cnt_d;

  logic [DATA_WIDTH:0]   tn, td, tn_sub, td_sub;
  logic                  ge_n, ge_d;

  assign num_neg = -num_i;
  assign den_neg = -den_i;
  assign num_mag = num_i[DATA_WIDTH-1] ? num_neg : num_i;
  assign den_mag = den_i[DATA_WIDTH-1] ? den_neg : den_i;

  assign u_zero   = (u_q == '0);
  assign v_zero   = (v_q == '0);
  assign gcd_done = u_zero || v_zero;
  assign g_val    = (u_zero ? v_q : u_q) << k_q;
  assign uv_sum   = {1'b0, u_q} + {1'b0, v_q};

  always_comb begin
    u_d = u_q;
    v_d = v_q;
    k_d = k_q;
    case (ctrl_i.gop)
      rau_pkg::G_INIT: begin
        u_d = num_mag;
        v_d = den_mag;
        k_d = '0;
      end
      rau_pkg::G_STEP: begin
        if (!gcd_done) begin
          if (!u_q[0] && !v_q[0]) begin
            u_d = u_q >> 1;
            v_d = v_q >> 1;
            k_d = k_q + 1'b1;
          end else if (!u_q[0]) begin
            u_d = u_q >> 1;
          end else if (!v_q[0]) begin
            v_d = v_q >> 1;
          end else if (u_q >= v_q) begin
            u_d = (u_q - v_q) >> 1;
          end else begin
            v_d = (v_q - u_q) >> 1;
          end
        end
      end
      default: ;
    endcase
  end

  assign tn     = {rn_q, an_q[DATA_WIDTH-1]};
  assign td     = {rd_q, ad_q[DATA_WIDTH-1]};
  assign ge_n   = tn >= {1'b0, g_q};
  assign ge_d   = td >= {1'b0, g_q};
  assign tn_sub = tn - {1'b0, g_q};
  assign td_sub = td - {1'b0, g_q};

  always_comb begin
    cnt_d = cnt_q;
    case (ctrl_i.dop)
      rau_pkg::D_INIT: cnt_d = (u_zero && v_zero) ? '0 : CntWidth'(DATA_WIDTH);
      rau_pkg::D_STEP: if (cnt_q != '0) cnt_d = cnt_q - 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      cnt_q <= '0;
    end else begin
      k_q   <= k_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u_q <= u_d;
    v_q <= v_d;
    if (ctrl_i.dop == rau_pkg::D_INIT) begin
      g_q  <= g_val;
      an_q <= num_mag;
      ad_q <= den_mag;
      rn_q <= '0;
      rd_q <= '0;
      sn_q <= num_i[DATA_WIDTH-1];
      sd_q <= den_i[DATA_WIDTH-1];
    end else if (ctrl_i.dop == rau_pkg::D_STEP && cnt_q != '0) begin
      an_q <= {an_q[DATA_WIDTH-2:0], ge_n};
      ad_q <= {ad_q[DATA_WIDTH-2:0], ge_d};
      rn_q <= ge_n ? tn_sub[DATA_WIDTH-1:0] : tn[DATA_WIDTH-1:0];
      rd_q <= ge_d ? td_sub[DATA_WIDTH-1:0] : td[DATA_WIDTH-1:0];
    end
  end

  assign num_o = sn_q ? -an_q : an_q;
  assign den_o = sd_q ? -ad_q : ad_q;

  assign stat_o.gcd_busy = !gcd_done;
  assign stat_o.g_zero   = u_zero && v_zero;
  assign stat_o.div_more = cnt_q > CntWidth'(1);

  `RAU_ASSERT_IMPL(a_div_step_live, ctrl_i.dop == rau_pkg::D_STEP, cnt_q != '0, "divide step with no count")
  `RAU_ASSERT_IMPL(a_div_nonzero, cnt_q != '0, g_q != '0, "division by zero gcd")
  `RAU_ASSERT_NEXT(a_gcd_progress, ctrl_i.gop == rau_pkg::G_STEP && !gcd_done, uv_sum < $past(uv_sum), "gcd step made no progress")

endmodule

`default_nettype wire

/* rtl/rational_arithmetic_unit.sv */
// Top level: microcoded sequencer, operand store, multiplier and result register.
//
// Channel | Valid / stall            | Payload
// in      | in_valid_i / in_stall_o  | req_type_i, left_num_i, left_den_i, right_num_i, right_den_i
// out     | out_valid_o / out_stall_i| res_num_o, res_den_o, is_equal_o, status_o
//
// One request in flight; a reduction pass is a gcd loop and then a divide loop over
// R = 2*OPERAND_WIDTH+1 bits; arithmetic requests run three passes plus load, multiply
// and finish steps, equality requests two passes.
// The gcd and divide loops of the reduction unit are bit-serial.
// Reset clears the sequencer and the output valid. A finished result waits in the
// output register; the next beat is taken while it is stalled.
`default_nettype none
`include "rational_arithmetic_unit_defines.svh"

module rational_arithmetic_unit #(
  parameter int unsigned OPERAND_WIDTH = rau_pkg::OperandWidthDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [2:0]                      req_type_i,
  input  logic signed [OPERAND_WIDTH-1:0] left_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] left_den_i,
  input  logic signed [OPERAND_WIDTH-1:0] right_num_i,
  input  logic signed [OPERAND_WIDTH-1:0] right_den_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [2*OPERAND_WIDTH:0] res_num_o,
  output logic signed [2*OPERAND_WIDTH:0] res_den_o,
  output logic                            is_equal_o,
  output logic                            status_o
);

  localparam int unsigned ResWidth  = 2 * OPERAND_WIDTH + 1;
  localparam int unsigned ProdWidth = 2 * OPERAND_WIDTH;

  logic              busy_q, busy_d;
  rau_pkg::pc_t      pc_q, pc_d;
  rau_pkg::uword_t   uw;
  rau_pkg::red_ctrl_t red_ctrl;
  rau_pkg::red_stat_t red_stat;
  logic              take, op_bad, out_free, fin_fire;

  logic [2:0]                      op_q;
  logic signed [OPERAND_WIDTH-1:0] ln_q, ld_q, rn_q, rd_q;
  logic signed [ResWidth-1:0]      wn_q, wn_d, wd_q, wd_d;
  logic signed [ResWidth-1:0]      red_num, red_den, p_ext;
  logic signed [OPERAND_WIDTH-1:0] mul_a, mul_b;
  logic signed [ProdWidth-1:0]     p_q;

  logic                      out_valid_q;
  logic signed [ResWidth-1:0] res_num_q, res_den_q;
  logic                      is_equal_q, status_q;

  assign uw         = rau_pkg::ucode(pc_q);
  assign in_stall_o = busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fin_fire   = busy_q && (uw.fin != rau_pkg::F_NONE) && out_free;
  assign op_bad     = !(op_q inside {rau_pkg::OP_ADD, rau_pkg::OP_SUB, rau_pkg::OP_MUL,
                                     rau_pkg::OP_DIV, rau_pkg::OP_EQ});

  always_comb begin
    case (uw.cond)
      rau_pkg::C_GCD_BUSY: take = red_stat.gcd_busy;
      rau_pkg::C_G_ZERO:   take = red_stat.g_zero;
      rau_pkg::C_DIV_MORE: take = red_stat.div_more;
      rau_pkg::C_OP_EQ:    take = (op_q == rau_pkg::OP_EQ);
      rau_pkg::C_OP_BAD:   take = op_bad;
      default:             take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (in_valid_i) begin
        busy_d = 1'b1;
        pc_d   = '0;
      end
    end else if (uw.fin != rau_pkg::F_NONE) begin
      if (out_free) busy_d = 1'b0;
    end else begin
      pc_d = take ? uw.target : pc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  always_comb begin
    red_ctrl.gop = rau_pkg::G_NONE;
    red_ctrl.dop = rau_pkg::D_NONE;
    if (busy_q) red_ctrl = uw.red;
  end

  rau_reduce #(
    .DATA_WIDTH(ResWidth)
  ) u_reduce (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (red_ctrl),
    .num_i  (wn_q),
    .den_i  (wd_q),
    .stat_o (red_stat),
    .num_o  (red_num),
    .den_o  (red_den)
  );

  always_comb begin
    mul_a = ln_q;
    mul_b = rd_q;
    case (uw.mul)
      rau_pkg::M_N1: begin
        mul_a = ln_q;
        mul_b = (op_q == rau_pkg::OP_MUL) ? rn_q : rd_q;
      end
      rau_pkg::M_N2: begin
        mul_a = rn_q;
        mul_b = ld_q;
      end
      rau_pkg::M_D: begin
        mul_a = ld_q;
        mul_b = (op_q == rau_pkg::OP_DIV) ? rn_q : rd_q;
      end
      default: ;
    endcase
  end

  assign p_ext = ResWidth'(p_q);

  always_comb begin
    wn_d = wn_q;
    wd_d = wd_q;
    if (busy_q) begin
      case (uw.wsel)
        rau_pkg::WS_LEFT: begin
          wn_d = ResWidth'(ln_q);
          wd_d = ResWidth'(ld_q);
        end
        rau_pkg::WS_RIGHT: begin
          wn_d = ResWidth'(rn_q);
          wd_d = ResWidth'(rd_q);
        end
        rau_pkg::WS_QUOT: begin
          wn_d = red_num;
          wd_d = red_den;
        end
        rau_pkg::WS_PROD_N: wn_d = p_ext;
        rau_pkg::WS_COMBINE_N: begin
          case (op_q)
            rau_pkg::OP_ADD: wn_d = wn_q + p_ext;
            rau_pkg::OP_SUB: wn_d = wn_q - p_ext;
            default:         wn_d = wn_q;
          endcase
        end
        rau_pkg::WS_PROD_D: wd_d = p_ext;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    wn_q <= wn_d;
    wd_q <= wd_d;
    if (busy_q && uw.mul != rau_pkg::M_NONE) p_q <= mul_a * mul_b;
    if (!busy_q && in_valid_i) begin
      op_q <= req_type_i;
      ln_q <= left_num_i;
      ld_q <= left_den_i;
      rn_q <= right_num_i;
      rd_q <= right_den_i;
    end else if (busy_q) begin
      if (uw.save_l) begin
        ln_q <= wn_q[OPERAND_WIDTH-1:0];
        ld_q <= wd_q[OPERAND_WIDTH-1:0];
      end
      if (uw.save_r) begin
        rn_q <= wn_q[OPERAND_WIDTH-1:0];
        rd_q <= wd_q[OPERAND_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      case (uw.fin)
        rau_pkg::F_ARITH: begin
          res_num_q  <= wn_q;
          res_den_q  <= wd_q;
          is_equal_q <= 1'b0;
          status_q   <= (ld_q == '0) || (rd_q == '0) || (wd_q == '0);
        end
        rau_pkg::F_EQ: begin
          res_num_q  <= '0;
          res_den_q  <= '0;
          is_equal_q <= (ln_q == rn_q) && (ld_q == rd_q);
          status_q   <= (ld_q == '0) || (rd_q == '0);
        end
        default: begin
          res_num_q  <= '0;
          res_den_q  <= '0;
          is_equal_q <= 1'b0;
          status_q   <= 1'b0;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign is_equal_o  = is_equal_q;
  assign status_o    = status_q;

  `RAU_ASSERT_IMPL(a_pc_range, busy_q, pc_q <= rau_pkg::PcFinZero, "sequencer left the program")
  `RAU_ASSERT_NEXT(a_fin_done, fin_fire, !busy_q && out_valid_o, "no result after finish")
  `RAU_ASSERT_IMPL(a_eq_zero_frac, out_valid_o && is_equal_o,
                   res_num_o == '0 && res_den_o == '0, "equality result carries a fraction")

endmodule

`default_nettype wire

/* tb/tb_rational_arithmetic_unit.sv */
// Self-checking testbench for rational_arithmetic_unit: directed table, then random beats.
`timescale 1ns / 1ps

module tb_rational_arithmetic_unit;

  localparam int OW          = 16;
  localparam int RW          = 2 * OW + 1;
  localparam int NumRandom   = 850;
  localparam int IdleLimit   = 20000;
  localparam int DrainCycles = 400;
  localparam int HoldCycles  = 3000;
  localparam int HoldAfter   = 60;
  localparam int MaxReports  = 10;

  localparam logic [2:0] OpRsvd5 = 3'd5;
  localparam logic [2:0] OpRsvd6 = 3'd6;
  localparam logic [2:0] OpRsvd7 = 3'd7;

  typedef struct packed {
    logic signed [RW-1:0] num;
    logic signed [RW-1:0] den;
    logic                 eq;
    logic                 st;
  } frac_res_t;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [OW-1:0] ln;
    logic signed [OW-1:0] ld;
    logic signed [OW-1:0] rn;
    logic signed [OW-1:0] rd;
    logic                 fixed;
    frac_res_t            res;
  } frac_row_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic [2:0]           req_type_i  = '0;
  logic signed [OW-1:0] left_num_i  = '0;
  logic signed [OW-1:0] left_den_i  = '0;
  logic signed [OW-1:0] right_num_i = '0;
  logic signed [OW-1:0] right_den_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic signed [RW-1:0] res_num_o;
  logic signed [RW-1:0] res_den_o;
  logic                 is_equal_o;
  logic                 status_o;

  frac_res_t pend_res = '0;
  frac_res_t pending[$];
  int        errors      = 0;
  int        idle_cycles = 0;
  int        burst_left  = 8;

  int stall_pct = 0;
  int mode_left = 0;
  int hold_left = 0;
  int rx_beats  = 0;
  bit hold_done = 1'b0;

  rational_arithmetic_unit #(
    .OPERAND_WIDTH(OW)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .req_type_i (req_type_i),
    .left_num_i (left_num_i),
    .left_den_i (left_den_i),
    .right_num_i(right_num_i),
    .right_den_i(right_den_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .res_num_o  (res_num_o),
    .res_den_o  (res_den_o),
    .is_equal_o (is_equal_o),
    .status_o   (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Divide both parts by the non-negative gcd; 0/0 stays as is.
  function automatic void frac_reduce(inout longint n, inout longint d);
    longint a, b, t;
    a = (n < 0) ? -n : n;
    b = (d < 0) ? -d : d;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    if (a != 0) begin
      n = n / a;
      d = d / a;
    end
  endfunction

  function automatic frac_res_t rat_predict(logic [2:0] op, logic signed [OW-1:0] ln_i,
                                            logic signed [OW-1:0] ld_i,
                                            logic signed [OW-1:0] rn_i,
                                            logic signed [OW-1:0] rd_i);
    longint    ln, ld, rn, rd, n, d;
    frac_res_t r;
    r  = '0;
    ln = ln_i;
    ld = ld_i;
    rn = rn_i;
    rd = rd_i;
    n  = 0;
    d  = 0;
    if (op <= rau_pkg::OP_EQ) begin
      frac_reduce(ln, ld);
      frac_reduce(rn, rd);
      r.st = (ld == 0 || rd == 0);
      if (op == rau_pkg::OP_EQ) begin
        r.eq = (ln == rn && ld == rd);
      end else begin
        case (op)
          rau_pkg::OP_ADD: begin
            n = ln * rd + rn * ld;
            d = ld * rd;
          end
          rau_pkg::OP_SUB: begin
            n = ln * rd - rn * ld;
            d = ld * rd;
          end
          rau_pkg::OP_MUL: begin
            n = ln * rn;
            d = ld * rd;
          end
          default: begin
            n = ln * rd;
            d = ld * rn;
          end
        endcase
        frac_reduce(n, d);
        if (d == 0) r.st = 1'b1;
        r.num = n[RW-1:0];
        r.den = d[RW-1:0];
      end
    end
    return r;
  endfunction

  function automatic frac_row_t mk_row(logic [2:0] op, int ln, int ld, int rn, int rd,
                                       bit fixed = 1'b0, longint num = 0, longint den = 0,
                                       bit eq = 1'b0, bit st = 1'b0);
    frac_row_t r;
    r.op        = op;
    r.ln        = OW'(ln);
    r.ld        = OW'(ld);
    r.rn        = OW'(rn);
    r.rd        = OW'(rd);
    r.fixed     = fixed;
    r.res.num   = num[RW-1:0];
    r.res.den   = den[RW-1:0];
    r.res.eq    = eq;
    r.res.st    = st;
    return r;
  endfunction

  function automatic logic signed [OW-1:0] pick_val();
    int kind, v;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: return OW'($urandom);
      4, 5, 6:    return OW'(int'($urandom_range(0, 40)) - 20);
      7: begin
        case ($urandom_range(0, 4))
          0:       return {1'b1, {(OW-1){1'b0}}};
          1:       return {1'b0, {(OW-1){1'b1}}};
          2:       return '1;
          3:       return OW'(1);
          default: return '0;
        endcase
      end
      8: begin
        v = int'($urandom_range(1, 255)) << $urandom_range(0, 7);
        return OW'($urandom_range(0, 1) ? -v : v);
      end
      default: return '0;
    endcase
  endfunction

  function automatic frac_row_t rand_row();
    frac_row_t r;
    int        a, b, k;
    r = '0;
    if ($urandom_range(0, 99) < 4) r.op = 3'($urandom_range(OpRsvd5, OpRsvd7));
    else r.op = 3'($urandom_range(rau_pkg::OP_ADD, rau_pkg::OP_EQ));
    if (r.op == rau_pkg::OP_EQ && $urandom_range(0, 1)) begin
      // scaled copies so that equal values show up often
      a = int'($urandom_range(0, 254)) - 127;
      b = int'($urandom_range(0, 254)) - 127;
      k = int'($urandom_range(1, 64));
      if ($urandom_range(0, 1)) k = -k;
      r.ln = OW'(a);
      r.ld = OW'(b);
      r.rn = OW'(a * k);
      r.rd = OW'(b * k);
    end else begin
      r.ln = pick_val();
      r.ld = pick_val();
      r.rn = pick_val();
      r.rd = pick_val();
    end
    return r;
  endfunction

  task automatic offer_beat(input frac_row_t row);
    req_type_i  <= row.op;
    left_num_i  <= row.ln;
    left_den_i  <= row.ld;
    right_num_i <= row.rn;
    right_den_i <= row.rd;
    pend_res    <= row.fixed ? row.res : rat_predict(row.op, row.ln, row.ld, row.rn, row.rd);
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    burst_left--;
    if (burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(40, 80);
      else burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending.size() != 0);
  endtask

  initial begin
    frac_row_t dir_rows[$];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    dir_rows.push_back(mk_row(rau_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6));
    dir_rows.push_back(mk_row(rau_pkg::OP_SUB, 1, 2, 1, 2, 1, 0, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_MUL, 2, 4, 3, 9, 1, 1, 6));
    dir_rows.push_back(mk_row(rau_pkg::OP_DIV, 1, 2, 1, 4, 1, 2, 1));
    // denominator sign is kept
    dir_rows.push_back(mk_row(rau_pkg::OP_ADD, 2, -4, 0, 1, 1, 1, -2));
    dir_rows.push_back(mk_row(rau_pkg::OP_EQ, 1, 2, 2, 4, 1, 0, 0, 1, 0));
    dir_rows.push_back(mk_row(rau_pkg::OP_EQ, 1, 2, -1, -2, 1, 0, 0, 0, 0));
    // zero over zero, zero denominators
    dir_rows.push_back(mk_row(rau_pkg::OP_ADD, 0, 0, 1, 1, 1, 0, 0, 0, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_MUL, 3, 0, 2, 5, 1, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_DIV, 1, 2, 0, 3, 1, 1, 0, 0, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_EQ, 3, 0, 5, 0, 1, 0, 0, 1, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_EQ, 0, 0, 0, 0, 1, 0, 0, 1, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_DIV, 5, 7, 0, 0));
    // unused codes
    dir_rows.push_back(mk_row(OpRsvd5, 3, 4, 5, 6, 1));
    dir_rows.push_back(mk_row(OpRsvd6, -32768, -32768, -32768, -32768, 1));
    dir_rows.push_back(mk_row(OpRsvd7, 32767, 32767, 32767, 32767, 1));
    // extremes
    dir_rows.push_back(mk_row(rau_pkg::OP_MUL, -32768, 1, -32768, 1, 1, 1073741824, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_EQ, -32768, -32768, -1, -1, 1, 0, 0, 1, 0));
    dir_rows.push_back(mk_row(rau_pkg::OP_SUB, 32767, 32767, 32767, 32767, 1, 0, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_ADD, 32767, 2, 32767, 2, 1, 32767, 1));
    dir_rows.push_back(mk_row(rau_pkg::OP_ADD, -32768, 32767, -32768, 32765));
    dir_rows.push_back(mk_row(rau_pkg::OP_SUB, 32767, -32768, -32768, 32767));
    dir_rows.push_back(mk_row(rau_pkg::OP_DIV, -32768, 32767, 32767, -32768));
    dir_rows.push_back(mk_row(rau_pkg::OP_MUL, 32767, -32768, -32768, 32767));

    foreach (dir_rows[i]) offer_beat(dir_rows[i]);
    pause_until_drained();

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) pause_until_drained();
      offer_beat(rand_row());
    end
    in_valid_i <= 1'b0;

    do @(posedge clk_i); while (pending.size() != 0);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0 && pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Result side: random stall mix, plus one long hold-off to back up the input.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) rx_beats++;
      if (!hold_done && rx_beats >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (mode_left == 0) begin
        mode_left = $urandom_range(64, 512);
        case ($urandom_range(0, 3))
          0:       stall_pct = 0;
          1:       stall_pct = 30;
          2:       stall_pct = 75;
          default: stall_pct = 95;
        endcase
      end else begin
        mode_left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : chk
    frac_res_t want, got;
    bit        in_beat, out_beat;
    if (rst_ni) begin
      in_beat  = in_valid_i && !in_stall_o;
      out_beat = out_valid_o && !out_stall_i;
      if (in_beat) pending.push_back(pend_res);
      if (out_beat) begin
        got = '{num: res_num_o, den: res_den_o, eq: is_equal_o, st: status_o};
        if (pending.size() == 0) begin
          if (errors < MaxReports)
            $display("%0t: unexpected beat num=%0d den=%0d eq=%0b st=%0b",
                     $time, got.num, got.den, got.eq, got.st);
          errors++;
        end else begin
          want = pending.pop_front();
          if (got.num !== want.num || got.den !== want.den ||
              got.eq !== want.eq || got.st !== want.st) begin
            if (errors < MaxReports)
              $display("%0t: exp %0d/%0d eq=%0b st=%0b, got %0d/%0d eq=%0b st=%0b",
                       $time, want.num, want.den, want.eq, want.st,
                       got.num, got.den, got.eq, got.st);
            errors++;
          end
        end
      end
      if (in_beat || out_beat) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("%0t: no beat for %0d cycles", $time, IdleLimit);
          $display("RESULT: ERROR");
          $finish;
        end
      end
    end
  end

endmodule
